// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, sampled on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define DPT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// condition must never be true outside reset
`define DPT_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== rtl/dpt_pkg.sv =====
// ----------------------------------------------------------------------------
// dpt_pkg
// Types, codes and sizes shared by the debounced pulse timer.
// ----------------------------------------------------------------------------
`default_nettype none

package dpt_pkg;

  localparam int TIMER_BITS = 32;
  localparam int CMP_W      = (TIMER_BITS > 32) ? TIMER_BITS : 32;

  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_PULSE  = 2'd1;
  localparam logic [1:0] CMD_WAIT   = 2'd2;
  localparam logic [1:0] CMD_CANCEL = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_THERE   = 2'd2;

  localparam logic [1:0] REG_STABLE_TICKS = 2'd0;
  localparam logic [1:0] REG_WAIT_LIMIT   = 2'd1;
  localparam logic [1:0] REG_MAX_PULSE    = 2'd2;

  localparam logic [15:0] STABLE_TICKS_RST = 16'd20;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_WAIT = 3'b010,
    PH_MEAS = 3'b100
  } phase_t;

  typedef struct packed {
    logic                  prev_raw;
    logic                  stable_value;
    logic [15:0]           settle_count;
    phase_t                phase;
    logic [TIMER_BITS-1:0] phase_timer;
    logic                  is_pulse_op;
  } state_t;

  typedef struct packed {
    logic [15:0] stable_ticks;
    logic [31:0] wait_limit;
    logic [31:0] max_pulse;
  } cfg_t;

  typedef struct packed {
    logic        stable_level;
    logic        toggled;
    logic        busy_res;
    logic        op_done;
    logic [1:0]  op_status;
    logic [31:0] elapsed_ticks;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/dpt_step.sv =====
// ----------------------------------------------------------------------------
// dpt_step
// One tick of debounce plus command sequencing: next state and result.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt_step import dpt_pkg::*; (
  input  var state_t  cur,
  input  var cfg_t    cfg,
  input  wire         pin_level,
  input  wire [1:0]   command,
  input  wire         target_level,
  output state_t      nxt,
  output result_t     res
);

  logic [15:0]           settle_next;
  logic                  tog;
  logic [TIMER_BITS-1:0] timer_inc;
  logic [CMP_W-1:0]      timer_ext;
  logic [CMP_W-1:0]      len;
  logic                  done;
  logic [1:0]            status;

  always_comb begin
    nxt = cur;
    tog = 1'b0;
    done = 1'b0;
    status = ST_OK;
    len = '0;

    if (pin_level != cur.prev_raw) begin
      settle_next = '0;
    end else if (cur.settle_count != '1) begin
      settle_next = cur.settle_count + 16'd1;
    end else begin
      settle_next = cur.settle_count;
    end
    nxt.settle_count = settle_next;
    nxt.prev_raw = pin_level;
    if (settle_next > cfg.stable_ticks && pin_level != cur.stable_value) begin
      nxt.stable_value = pin_level;
      tog = 1'b1;
    end

    timer_inc = (cur.phase_timer == '1) ? cur.phase_timer : cur.phase_timer + 1'b1;
    timer_ext = CMP_W'(timer_inc);

    unique case (cur.phase)
      PH_WAIT, PH_MEAS: begin
        if (command == CMD_CANCEL) begin
          nxt.phase = PH_IDLE;
          nxt.phase_timer = '0;
        end else begin
          nxt.phase_timer = timer_inc;
          if (cur.phase == PH_WAIT) begin
            if (tog) begin
              if (cur.is_pulse_op) begin
                nxt.phase = PH_MEAS;
                nxt.phase_timer = '0;
              end else begin
                done = 1'b1;
                len = timer_ext;
              end
            end else if (cfg.wait_limit != '0 && timer_ext > CMP_W'(cfg.wait_limit)) begin
              done = 1'b1;
              status = ST_TIMEOUT;
              len = cur.is_pulse_op ? '0 : timer_ext;
            end
          end else begin
            if (tog) begin
              done = 1'b1;
              len = timer_ext;
            end else if (cfg.max_pulse != '0 && timer_ext > CMP_W'(cfg.max_pulse)) begin
              done = 1'b1;
              status = ST_TIMEOUT;
            end
          end
          if (done) begin
            nxt.phase = PH_IDLE;
            nxt.phase_timer = '0;
          end
        end
      end
      default: begin
        nxt.phase = PH_IDLE;
        if (command == CMD_PULSE) begin
          nxt.phase = PH_WAIT;
          nxt.is_pulse_op = 1'b1;
          nxt.phase_timer = '0;
        end else if (command == CMD_WAIT) begin
          if (nxt.stable_value == target_level) begin
            done = 1'b1;
            status = ST_THERE;
          end else begin
            nxt.phase = PH_WAIT;
            nxt.is_pulse_op = 1'b0;
            nxt.phase_timer = '0;
          end
        end
      end
    endcase

    res.stable_level = nxt.stable_value;
    res.toggled = tog;
    res.busy_res = (nxt.phase != PH_IDLE);
    res.op_done = done;
    res.op_status = status;
    res.elapsed_ticks = (len > CMP_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : len[31:0];
  end

endmodule

`default_nettype wire

// ===== rtl/debounced_pulse_timer.sv =====
// Result: a request's result is registered and shows in the cycle after it is accepted.
// Throughput: one request per cycle; the one-tick step logic sits between the
// state registers and the result register; a result held by a stalled consumer
// holds off new requests until it is taken.
// Reset: synchronous rst returns debounce and command state to zero/idle and the
// registers to stable_ticks 20, wait limit 0, max_pulse 0; no request is taken in reset.
// ----------------------------------------------------------------------------
// debounced_pulse_timer
// Debounced pin sampler with pulse-width and wait-for-level timing per tick.
// ----------------------------------------------------------------------------
`default_nettype none

module debounced_pulse_timer import dpt_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire        pin_level,
  input  wire [1:0]  command,
  input  wire        target_level,
  output logic       out_valid,
  input  wire        out_ready,
  output logic       stable_level,
  output logic       toggled,
  output logic       busy_res,
  output logic       op_done,
  output logic [1:0] op_status,
  output logic [31:0] elapsed_ticks,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [1:0]  cfg_index,
  input  wire [31:0] cfg_data
);

`include "assert_macros.svh"

  state_t  state;
  state_t  state_next;
  cfg_t    cfg;
  result_t res_next;
  result_t res;
  logic    in_fire;

  assign in_ready  = !rst && (!out_valid || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = !rst;

  dpt_step u_step (
    .cur          (state),
    .cfg          (cfg),
    .pin_level    (pin_level),
    .command      (command),
    .target_level (target_level),
    .nxt          (state_next),
    .res          (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stable_ticks <= STABLE_TICKS_RST;
      cfg.wait_limit <= '0;
      cfg.max_pulse <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STABLE_TICKS: cfg.stable_ticks <= cfg_data[15:0];
        REG_WAIT_LIMIT:   cfg.wait_limit <= cfg_data;
        REG_MAX_PULSE:    cfg.max_pulse <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.prev_raw <= 1'b0;
      state.stable_value <= 1'b0;
      state.settle_count <= '0;
      state.phase <= PH_IDLE;
      state.phase_timer <= '0;
      state.is_pulse_op <= 1'b0;
      out_valid <= 1'b0;
    end else if (in_fire) begin
      state <= state_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res <= res_next;
    end
  end

  assign stable_level  = res.stable_level;
  assign toggled       = res.toggled;
  assign busy_res      = res.busy_res;
  assign op_done       = res.op_done;
  assign op_status     = res.op_status;
  assign elapsed_ticks = res.elapsed_ticks;

  `DPT_ASSERT(a_done_not_busy, out_valid && op_done |-> !busy_res)
  `DPT_ASSERT(a_idle_result_quiet,
              out_valid && !op_done |-> op_status == ST_OK && elapsed_ticks == '0)
  `DPT_ASSERT(a_idle_timer_clear, state.phase == PH_IDLE |-> state.phase_timer == '0)
  `DPT_ASSERT(a_busy_tracks_phase,
              $past(in_fire) |-> busy_res == (state.phase != PH_IDLE))
  `DPT_ASSERT_NEVER(a_toggle_no_change,
                    $past(in_fire) && toggled && $stable(state.stable_value))

endmodule

`default_nettype wire

// ===== tb/tb_debounced_pulse_timer.sv =====
// ----------------------------------------------------------------------------
// tb_debounced_pulse_timer
// Self-checking bench for the debounced pulse timer. Pin ticks with pulse,
// wait-for-level and cancel commands are streamed through a valid/ready
// driver under several register settings; every accepted request is run
// through a cycle-free tick predictor and the monitor compares each result
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_debounced_pulse_timer;
  import dpt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic       pin;
    logic [1:0] cmd;
    logic       tgt;
  } tick_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        pin_level = 1'b0;
  logic [1:0]  command = CMD_NONE;
  logic        target_level = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        stable_level;
  logic        toggled;
  logic        busy_res;
  logic        op_done;
  logic [1:0]  op_status;
  logic [31:0] elapsed_ticks;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_STABLE_TICKS;
  logic [31:0] cfg_data = '0;

  debounced_pulse_timer uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pin_level    (pin_level),
    .command      (command),
    .target_level (target_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stable_level (stable_level),
    .toggled      (toggled),
    .busy_res     (busy_res),
    .op_done      (op_done),
    .op_status    (op_status),
    .elapsed_ticks(elapsed_ticks),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  tick_req_t tick_queue[$];
  result_t   tick_results_due[$];
  int        failures = 0;
  bit        tx_gaps = 1'b0;
  bit        rx_stalls = 1'b0;

  // predictor state and register copy
  cfg_t                  regs;
  logic                  prev_pin;
  logic                  stable_pin;
  logic [15:0]           settle_cnt;
  phase_t                op_phase;
  logic [TIMER_BITS-1:0] op_timer;
  logic                  pulse_mode;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic result_t advance_tick(input tick_req_t t);
    result_t     res;
    logic        tog;
    logic        done;
    logic [1:0]  st;
    logic [63:0] len;
    tog  = 1'b0;
    done = 1'b0;
    st   = ST_OK;
    len  = '0;
    if (t.pin != prev_pin) settle_cnt = '0;
    else if (settle_cnt != 16'hFFFF) settle_cnt = settle_cnt + 16'd1;
    prev_pin = t.pin;
    if (settle_cnt > regs.stable_ticks && t.pin != stable_pin) begin
      stable_pin = t.pin;
      tog = 1'b1;
    end
    if (op_phase != PH_IDLE) begin
      if (t.cmd == CMD_CANCEL) begin
        op_phase = PH_IDLE;
        op_timer = '0;
      end else begin
        if (op_timer != '1) op_timer = op_timer + 1'b1;
        if (op_phase == PH_WAIT) begin
          if (tog) begin
            if (pulse_mode) begin
              op_phase = PH_MEAS;
              op_timer = '0;
            end else begin
              done = 1'b1;
              len  = 64'(op_timer);
            end
          end else if (regs.wait_limit != 0 && 64'(op_timer) > 64'(regs.wait_limit)) begin
            done = 1'b1;
            st   = ST_TIMEOUT;
            len  = pulse_mode ? 64'd0 : 64'(op_timer);
          end
        end else begin
          if (tog) begin
            done = 1'b1;
            len  = 64'(op_timer);
          end else if (regs.max_pulse != 0 && 64'(op_timer) > 64'(regs.max_pulse)) begin
            done = 1'b1;
            st   = ST_TIMEOUT;
          end
        end
        if (done) begin
          op_phase = PH_IDLE;
          op_timer = '0;
        end
      end
    end else begin
      if (t.cmd == CMD_PULSE) begin
        op_phase   = PH_WAIT;
        pulse_mode = 1'b1;
        op_timer   = '0;
      end else if (t.cmd == CMD_WAIT) begin
        if (stable_pin == t.tgt) begin
          done = 1'b1;
          st   = ST_THERE;
        end else begin
          op_phase   = PH_WAIT;
          pulse_mode = 1'b0;
          op_timer   = '0;
        end
      end
    end
    res.stable_level  = stable_pin;
    res.toggled       = tog;
    res.busy_res      = (op_phase != PH_IDLE);
    res.op_done       = done;
    res.op_status     = st;
    res.elapsed_ticks = (len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len[31:0];
    return res;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  // request driver
  tick_req_t next_req;
  int        gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (tick_queue.size() != 0) begin
        next_req     = tick_queue.pop_front();
        pin_level    <= next_req.pin;
        command      <= next_req.cmd;
        target_level <= next_req.tgt;
        in_valid     <= 1'b1;
        gap_left     <= tx_gaps ? pick_gap() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: predict on accepted requests, check accepted results
  result_t want;
  int      stall_left = 0;
  int      stall_len;

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (in_valid && in_ready)
        tick_results_due.push_back(advance_tick('{pin_level, command, target_level}));
      if (out_valid && out_ready) begin
        if (tick_results_due.size() == 0) begin
          $error("result with no request outstanding");
          failures++;
        end else begin
          want = tick_results_due.pop_front();
          check_field("stable_level", 32'(want.stable_level), 32'(stable_level));
          check_field("toggled", 32'(want.toggled), 32'(toggled));
          check_field("busy_res", 32'(want.busy_res), 32'(busy_res));
          check_field("op_done", 32'(want.op_done), 32'(op_done));
          check_field("op_status", 32'(want.op_status), 32'(op_status));
          check_field("elapsed_ticks", want.elapsed_ticks, elapsed_ticks);
        end
      end
      if (stall_left != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (rx_stalls && out_valid && out_ready) begin
        stall_len  = pick_gap();
        out_ready  <= (stall_len == 0);
        stall_left <= (stall_len == 0) ? 0 : stall_len - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic set_reg(input logic [1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_STABLE_TICKS: regs.stable_ticks = data[15:0];
      REG_WAIT_LIMIT:   regs.wait_limit = data;
      REG_MAX_PULSE:    regs.max_pulse = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_tick(input logic pin, input logic [1:0] cmd, input logic tgt);
    tick_queue.push_back('{pin, cmd, tgt});
  endtask

  task automatic drain();
    do @(negedge clk);
    while (tick_queue.size() != 0 || in_valid || tick_results_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // well-formed level segments with random commands, plus some noise
  task automatic add_traffic(input int n);
    int        cap;
    int        seg;
    int        r;
    logic      lvl;
    tick_req_t t;
    cap = (regs.stable_ticks > 12) ? 12 : int'(regs.stable_ticks);
    lvl = 1'($urandom_range(0, 1));
    while (n > 0) begin
      lvl = ~lvl;
      r = $urandom_range(0, 99);
      if (r < 20) seg = $urandom_range(1, cap + 1);
      else if (r < 90) seg = $urandom_range(cap + 1, cap + 12);
      else seg = $urandom_range(cap + 12, cap + 60);
      repeat (seg) begin
        if (n == 0) break;
        t.pin = lvl;
        t.tgt = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 6) t.cmd = CMD_PULSE;
        else if (r < 12) t.cmd = CMD_WAIT;
        else if (r < 14) t.cmd = CMD_CANCEL;
        else if (r < 86) t.cmd = CMD_NONE;
        else begin
          t.pin = 1'($urandom_range(0, 1));
          t.cmd = 2'($urandom_range(0, 3));
        end
        tick_queue.push_back(t);
        n--;
      end
    end
  endtask

  logic [31:0] st_set [7];
  logic [31:0] mw_set [7];
  logic [31:0] mp_set [7];

  initial begin
    regs.stable_ticks = STABLE_TICKS_RST;
    regs.wait_limit   = '0;
    regs.max_pulse    = '0;
    prev_pin   = 1'b0;
    stable_pin = 1'b0;
    settle_cnt = '0;
    op_phase   = PH_IDLE;
    op_timer   = '0;
    pulse_mode = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: one-tick settle, short timeouts
    set_reg(REG_STABLE_TICKS, 32'd0);
    set_reg(REG_WAIT_LIMIT, 32'd2);
    set_reg(REG_MAX_PULSE, 32'd2);
    push_tick(0, CMD_WAIT, 0);    // already at level
    push_tick(0, CMD_CANCEL, 0);  // cancel while idle
    push_tick(1, CMD_PULSE, 0);
    push_tick(1, CMD_WAIT, 1);    // ignored while busy
    push_tick(0, CMD_NONE, 0);
    push_tick(0, CMD_NONE, 0);    // pulse measured
    push_tick(0, CMD_WAIT, 1);
    repeat (3) push_tick(0, CMD_NONE, 0);  // wait-level timeout
    push_tick(1, CMD_PULSE, 0);
    repeat (4) push_tick(1, CMD_NONE, 0);  // pulse-length timeout
    push_tick(1, CMD_PULSE, 0);
    push_tick(1, CMD_CANCEL, 0);  // cancel while busy
    push_tick(0, CMD_NONE, 0);
    push_tick(0, CMD_PULSE, 0);   // toggle on start tick not counted
    push_tick(0, CMD_NONE, 0);
    push_tick(1, CMD_NONE, 0);
    push_tick(1, CMD_NONE, 0);
    push_tick(0, CMD_NONE, 0);
    push_tick(0, CMD_WAIT, 0);
    push_tick(1, CMD_WAIT, 1);
    push_tick(1, CMD_NONE, 1);    // wait-level completes
    push_tick(1, CMD_PULSE, 1);
    repeat (3) push_tick(1, CMD_NONE, 1);  // no-toggle timeout on pulse
    drain();

    st_set = '{32'd0, {16'hA5A5, 16'd3}, 32'hFFFF_FFFF, 32'd2, 32'd1,
               32'($urandom_range(0, 6)), 32'($urandom_range(0, 6))};
    mw_set = '{32'd0, 32'd40, 32'd5, 32'hFFFF_FFFF, 32'd1,
               32'($urandom_range(0, 30)), 32'($urandom_range(0, 30))};
    mp_set = '{32'd0, 32'd25, 32'd3, 32'hFFFF_FFFF, 32'd1,
               32'($urandom_range(0, 30)), 32'($urandom_range(0, 30))};

    for (int i = 0; i < 7; i++) begin
      tx_gaps   = 1'((i + 1) % 2);
      rx_stalls = 1'(((i + 1) / 2) % 2);
      set_reg(REG_STABLE_TICKS, st_set[i]);
      set_reg(REG_WAIT_LIMIT, mw_set[i]);
      set_reg(REG_MAX_PULSE, mp_set[i]);
      if (i == 2) set_reg(REG_UNUSED, $urandom);
      if (i == 1) begin
        add_traffic(120);
        drain();
        add_traffic(125);
      end else begin
        add_traffic(245);
      end
      drain();
    end

    if (failures == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

endmodule
